// ===== hw/rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg: shared types, constants and functions of the RGB to HSV classifier
// Widths, register codes, stage payloads and the divider step used by the
// pipeline stages.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int unsigned CompW        = 8;   // color component
	localparam int unsigned HueW         = 9;   // hue in degrees
	localparam int unsigned PctW         = 7;   // saturation / lightness percent
	localparam int unsigned ClassW       = 2;
	localparam int unsigned CfgIdxW      = 3;
	localparam int unsigned CfgDataW     = 9;
	localparam int unsigned NumW         = 17;  // dividend: 60*6*255 < 2**17
	localparam int unsigned QuotW        = 9;
	localparam int unsigned BitsPerStage = 3;
	localparam int unsigned ProdW        = 15;  // 100*255 < 2**15
	localparam int unsigned PipeDepth    = 6;

	localparam int DivTop3 = QuotW - 1;
	localparam int DivTop4 = QuotW - 1 - BitsPerStage;
	localparam int DivTop5 = QuotW - 1 - 2 * BitsPerStage;

	typedef enum logic [ClassW-1:0] {
		CLASS_NONE   = 2'd0,
		CLASS_YELLOW = 2'd1,
		CLASS_BLUE   = 2'd2,
		CLASS_WHITE  = 2'd3
	} color_class_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_YELLOW_LO = 3'd0,
		REG_YELLOW_HI = 3'd1,
		REG_BLUE_LO   = 3'd2,
		REG_BLUE_HI   = 3'd3,
		REG_WHITE_LO  = 3'd4,
		REG_WHITE_HI  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [HueW-1:0] lo;
		logic [HueW-1:0] hi;
	} hue_window_t;

	typedef struct packed {
		hue_window_t yellow;
		hue_window_t blue;
		hue_window_t white;
	} class_cfg_t;

	localparam class_cfg_t CfgReset = '{
		yellow: '{lo: 9'd40,  hi: 9'd70},
		blue:   '{lo: 9'd180, hi: 9'd200},
		white:  '{lo: 9'd0,   hi: 9'd20}
	};

	// operands handed from the front end to the dividers
	typedef struct packed {
		logic [NumW-1:0]  hue_num;
		logic [CompW-1:0] hue_den;
		logic [NumW-1:0]  sat_num;
		logic [CompW-1:0] sat_den;
		logic [PctW-1:0]  light;
	} div_in_t;

	typedef struct packed {
		logic [NumW-1:0]  rem;
		logic [QuotW-1:0] quot;
	} div_part_t;

	typedef struct packed {
		div_part_t        h;
		div_part_t        s;
		logic [CompW-1:0] hue_den;
		logic [CompW-1:0] sat_den;
		logic [PctW-1:0]  light;
	} div_st_t;

	typedef struct packed {
		logic [HueW-1:0] hue;
		logic [PctW-1:0] saturation;
		logic [PctW-1:0] lightness;
	} hsv_t;

	typedef struct packed {
		logic [HueW-1:0] hue;
		logic [PctW-1:0] saturation;
		logic [PctW-1:0] lightness;
		color_class_t    color_class;
	} hsv_class_t;

	// restoring division, BitsPerStage quotient bits from top_bit down
	function automatic div_part_t div_step(input div_part_t part, input logic [CompW-1:0] den,
		input int top_bit);
		div_part_t       acc;
		logic [NumW-1:0] trial;
		int              sh;
		acc = part;
		for (int j = 0; j < int'(BitsPerStage); j++) begin
			sh    = top_bit - j;
			trial = NumW'(den) << sh;
			if (acc.rem >= trial) begin
				acc.rem  = acc.rem - trial;
				acc.quot = acc.quot | (QuotW'(1) << sh);
			end
		end
		return acc;
	endfunction

	function automatic div_st_t div_stage(input div_st_t st, input int top_bit);
		div_st_t nx;
		nx   = st;
		nx.h = div_step(st.h, st.hue_den, top_bit);
		nx.s = div_step(st.s, st.sat_den, top_bit);
		return nx;
	endfunction

	// floor(100*mx/255); x/255 == (x + 1 + x/256)/256 for x < 65535
	function automatic logic [PctW-1:0] light_pct(input logic [CompW-1:0] mx);
		logic [ProdW-1:0] x;
		logic [ProdW:0]   s;
		x = ProdW'(mx) * ProdW'(100);
		s = (ProdW+1)'(x) + (ProdW+1)'(1) + (ProdW+1)'(x >> 8);
		return PctW'(s >> 8);
	endfunction

endpackage

// ===== hw/rtl/rhc_ifs.sv =====
// ----------------------------------------------------------------------------
// rhc_ifs: stream and configuration interfaces of the classifier
// Pixel input, HSV result and register write channels (valid/ready).
// ----------------------------------------------------------------------------
interface rhc_pix_if;
	logic                     valid;
	logic                     ready;
	logic [rhc_pkg::CompW-1:0] red;
	logic [rhc_pkg::CompW-1:0] green;
	logic [rhc_pkg::CompW-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhc_hsv_if;
	logic                      valid;
	logic                      ready;
	logic [rhc_pkg::HueW-1:0]   hue;
	logic [rhc_pkg::PctW-1:0]   saturation;
	logic [rhc_pkg::PctW-1:0]   lightness;
	logic [rhc_pkg::ClassW-1:0] color_class;

	modport source (output valid, hue, saturation, lightness, color_class, input ready);
	modport sink   (input valid, hue, saturation, lightness, color_class, output ready);
endinterface

interface rhc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [rhc_pkg::CfgIdxW-1:0]  index;
	logic [rhc_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front: max/min search and divider operand setup (stages 1 and 2)
// Stage 1 finds max, min and the max channel; stage 2 forms the hue sector
// numerator, the saturation numerator and the lightness percent.
// ----------------------------------------------------------------------------
module rhc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rhc_pkg::CompW-1:0] red,
	input  logic [rhc_pkg::CompW-1:0] green,
	input  logic [rhc_pkg::CompW-1:0] blue,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rhc_pkg::div_in_t          out_data
);

	localparam int unsigned UW = rhc_pkg::CompW + 5;

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

	// stage 1
	logic [rhc_pkg::CompW-1:0] mx_c, mn_c;
	max_sel_t                  sel_c;
	logic                      v_s1, rdy_s1;
	logic [rhc_pkg::CompW-1:0] r_s1, g_s1, b_s1, mx_s1, delta_s1;
	max_sel_t                  sel_s1;

	// stage 2
	logic signed [UW-1:0]      rs, gs, bs, ds, u;
	logic [rhc_pkg::NumW-1:0]  uu, dd;
	rhc_pkg::div_in_t          d_c, d_s2;
	logic                      v_s2, rdy_s2;

	// ties go to red, then green
	always_comb begin
		mx_c  = red;
		mn_c  = red;
		sel_c = SEL_RED;
		if (green > mx_c) begin
			mx_c  = green;
			sel_c = SEL_GREEN;
		end
		if (green < mn_c)
			mn_c = green;
		if (blue > mx_c) begin
			mx_c  = blue;
			sel_c = SEL_BLUE;
		end
		if (blue < mn_c)
			mn_c = blue;
	end

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= in_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			r_s1     <= red;
			g_s1     <= green;
			b_s1     <= blue;
			mx_s1    <= mx_c;
			delta_s1 <= mx_c - mn_c;
			sel_s1   <= sel_c;
		end
		if (rdy_s2 && v_s1)
			d_s2 <= d_c;
	end

	// u = hue/60 scaled by delta, always in [0, 6*delta)
	always_comb begin
		rs = $signed(UW'(r_s1));
		gs = $signed(UW'(g_s1));
		bs = $signed(UW'(b_s1));
		ds = $signed(UW'(delta_s1));
		unique case (sel_s1)
			SEL_RED:   u = (g_s1 >= b_s1) ? (gs - bs) : (gs - bs + (ds <<< 2) + (ds <<< 1));
			SEL_GREEN: u = (ds <<< 1) + bs - rs;
			SEL_BLUE:  u = (ds <<< 2) + rs - gs;
			default:   u = '0;
		endcase
		uu = rhc_pkg::NumW'($unsigned(u));
		dd = rhc_pkg::NumW'(delta_s1);

		d_c.hue_num = (uu << 6) - (uu << 2);
		d_c.hue_den = (delta_s1 == '0) ? rhc_pkg::CompW'(1) : delta_s1;
		d_c.sat_num = (dd << 6) + (dd << 5) + (dd << 2);
		d_c.sat_den = (mx_s1 == '0) ? rhc_pkg::CompW'(1) : mx_s1;
		d_c.light   = rhc_pkg::light_pct(mx_s1);
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;

endmodule

// ===== hw/rtl/rhc_div.sv =====
// ----------------------------------------------------------------------------
// rhc_div: pipelined restoring dividers for hue and saturation (stages 3-5)
// Two dividers run in lockstep, three quotient bits per stage.
// ----------------------------------------------------------------------------
module rhc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rhc_pkg::div_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rhc_pkg::hsv_t    out_data
);

	rhc_pkg::div_st_t entry_c;
	rhc_pkg::div_st_t st_s3, st_s4, st_s5;
	logic             v_s3, v_s4, v_s5;
	logic             rdy_s3, rdy_s4, rdy_s5;

	always_comb begin
		entry_c.h.rem  = in_data.hue_num;
		entry_c.h.quot = '0;
		entry_c.s.rem  = in_data.sat_num;
		entry_c.s.quot = '0;
		entry_c.hue_den = in_data.hue_den;
		entry_c.sat_den = in_data.sat_den;
		entry_c.light   = in_data.light;
	end

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s3)
				v_s3 <= in_valid;
			if (rdy_s4)
				v_s4 <= v_s3;
			if (rdy_s5)
				v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid)
			st_s3 <= rhc_pkg::div_stage(entry_c, rhc_pkg::DivTop3);
		if (rdy_s4 && v_s3)
			st_s4 <= rhc_pkg::div_stage(st_s3, rhc_pkg::DivTop4);
		if (rdy_s5 && v_s4)
			st_s5 <= rhc_pkg::div_stage(st_s4, rhc_pkg::DivTop5);
	end

	assign out_valid           = v_s5;
	assign out_data.hue        = st_s5.h.quot;
	assign out_data.saturation = rhc_pkg::PctW'(st_s5.s.quot);
	assign out_data.lightness  = st_s5.light;

endmodule

// ===== hw/rtl/rhc_class.sv =====
// ----------------------------------------------------------------------------
// rhc_class: hue window classification and output register (stage 6)
// Yellow, blue and white windows are tested in that order, strict bounds.
// ----------------------------------------------------------------------------
module rhc_class (
	input  logic                clk,
	input  logic                arst_n,
	input  rhc_pkg::class_cfg_t cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  rhc_pkg::hsv_t       in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rhc_pkg::hsv_class_t out_data
);

	rhc_pkg::color_class_t cls_c;
	rhc_pkg::hsv_class_t   res_s6;
	logic                  v_s6;

	function automatic logic in_win(input logic [rhc_pkg::HueW-1:0] h,
		input rhc_pkg::hue_window_t w);
		return (h > w.lo) && (h < w.hi);
	endfunction

	always_comb begin
		priority if (in_win(in_data.hue, cfg.yellow))
			cls_c = rhc_pkg::CLASS_YELLOW;
		else if (in_win(in_data.hue, cfg.blue))
			cls_c = rhc_pkg::CLASS_BLUE;
		else if (in_win(in_data.hue, cfg.white))
			cls_c = rhc_pkg::CLASS_WHITE;
		else
			cls_c = rhc_pkg::CLASS_NONE;
	end

	assign in_ready = !v_s6 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (in_ready)
			v_s6 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_s6.hue         <= in_data.hue;
			res_s6.saturation  <= in_data.saturation;
			res_s6.lightness   <= in_data.lightness;
			res_s6.color_class <= cls_c;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = res_s6;

endmodule

// ===== hw/rtl/rgb_to_hsv_color_classifier_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_color_classifier_core: RGB to HSV conversion and color class
// Top level: window registers, front end, dividers and classifier stage.
// ----------------------------------------------------------------------------
//  port     dir   transaction
//  pixel    in    red, green, blue (8 bits each)
//  result   out   hue, saturation, lightness, color_class
//  cfg      in    index (0..5, others ignored), 9-bit data; always ready
//
//  Six register stages; while the result side keeps taking results, one
//  pixel per cycle is sustained; the hue and saturation dividers resolve
//  three quotient bits per stage over stages 3 to 5.
//  Each stage advances when it is empty or the next one advances, so a stalled
//  result lets empty stages behind it fill. Reset clears all valid bits and
//  loads the window registers with their defaults.
// ----------------------------------------------------------------------------
module rgb_to_hsv_color_classifier_core (
	input  logic       clk,
	input  logic       arst_n,
	rhc_pix_if.sink    pixel,
	rhc_hsv_if.source  result,
	rhc_cfg_if.sink    cfg
);

	rhc_pkg::class_cfg_t cfg_q;
	rhc_pkg::div_in_t    front_data;
	rhc_pkg::hsv_t       div_data;
	rhc_pkg::hsv_class_t res;
	logic                front_valid, front_ready;
	logic                div_valid, div_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rhc_pkg::CfgReset;
		end else if (cfg.valid && cfg.ready) begin
			unique case (rhc_pkg::cfg_reg_t'(cfg.index))
				rhc_pkg::REG_YELLOW_LO: cfg_q.yellow.lo <= cfg.data;
				rhc_pkg::REG_YELLOW_HI: cfg_q.yellow.hi <= cfg.data;
				rhc_pkg::REG_BLUE_LO:   cfg_q.blue.lo   <= cfg.data;
				rhc_pkg::REG_BLUE_HI:   cfg_q.blue.hi   <= cfg.data;
				rhc_pkg::REG_WHITE_LO:  cfg_q.white.lo  <= cfg.data;
				rhc_pkg::REG_WHITE_HI:  cfg_q.white.hi  <= cfg.data;
				default: ;
			endcase
		end
	end

	rhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.red       (pixel.red),
		.green     (pixel.green),
		.blue      (pixel.blue),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	rhc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	rhc_class u_class (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_data   (div_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res)
	);

	assign result.hue         = res.hue;
	assign result.saturation  = res.saturation;
	assign result.lightness   = res.lightness;
	assign result.color_class = res.color_class;

endmodule

// ===== hw/rtl/rhc_checker.sv =====
// ----------------------------------------------------------------------------
// rhc_checker: port-level assertions for the classifier core
// Tracks window registers and pipeline occupancy from the ports alone.
// ----------------------------------------------------------------------------
module rhc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rhc_pkg::HueW-1:0]     hue,
	input logic [rhc_pkg::PctW-1:0]     saturation,
	input logic [rhc_pkg::PctW-1:0]     lightness,
	input logic [rhc_pkg::ClassW-1:0]   color_class,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [rhc_pkg::CfgIdxW-1:0]  cfg_index,
	input logic [rhc_pkg::CfgDataW-1:0] cfg_data
);

	rhc_pkg::class_cfg_t   win_q;
	logic [3:0]            occ_q;
	logic                  in_acc, out_acc;
	rhc_pkg::color_class_t exp_cls;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= rhc_pkg::CfgReset;
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + 4'(in_acc) - 4'(out_acc);
			if (cfg_valid && cfg_ready) begin
				unique case (rhc_pkg::cfg_reg_t'(cfg_index))
					rhc_pkg::REG_YELLOW_LO: win_q.yellow.lo <= cfg_data;
					rhc_pkg::REG_YELLOW_HI: win_q.yellow.hi <= cfg_data;
					rhc_pkg::REG_BLUE_LO:   win_q.blue.lo   <= cfg_data;
					rhc_pkg::REG_BLUE_HI:   win_q.blue.hi   <= cfg_data;
					rhc_pkg::REG_WHITE_LO:  win_q.white.lo  <= cfg_data;
					rhc_pkg::REG_WHITE_HI:  win_q.white.hi  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		priority if (hue > win_q.yellow.lo && hue < win_q.yellow.hi)
			exp_cls = rhc_pkg::CLASS_YELLOW;
		else if (hue > win_q.blue.lo && hue < win_q.blue.hi)
			exp_cls = rhc_pkg::CLASS_BLUE;
		else if (hue > win_q.white.lo && hue < win_q.white.hi)
			exp_cls = rhc_pkg::CLASS_WHITE;
		else
			exp_cls = rhc_pkg::CLASS_NONE;
	end

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hue < 9'd360) && (saturation <= 7'd100) && (lightness <= 7'd100))
		else $error("result field out of range");

	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (color_class == exp_cls))
		else $error("color class does not match hue windows");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
			&& $stable(lightness) && $stable(color_class))
		else $error("stalled result changed");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occ_q != 4'd0))
		else $error("result without a pending pixel");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 4'(rhc_pkg::PipeDepth))
		else $error("more pixels in flight than pipeline stages");

endmodule

bind rgb_to_hsv_color_classifier_core rhc_checker u_rhc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pixel.valid),
	.in_ready    (pixel.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.hue         (result.hue),
	.saturation  (result.saturation),
	.lightness   (result.lightness),
	.color_class (result.color_class),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready),
	.cfg_index   (cfg.index),
	.cfg_data    (cfg.data)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of rgb_to_hsv_color_classifier_core
// Pixels go in through a queue-fed driver. A predictor computes hue,
// saturation, lightness and color class for each accepted pixel, using its
// own copy of the hue window registers. A monitor checks every result, field
// by field, against the oldest prediction. Both sides idle at random, and the
// windows are reloaded between batches while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ClkPeriod     = 10;
	localparam int NumWindowRegs = 6;
	localparam int PrintCap      = 40;

	// register indexes with no register behind them
	localparam logic [rhc_pkg::CfgIdxW-1:0] IdxSpareLo = 3'd6;
	localparam logic [rhc_pkg::CfgIdxW-1:0] IdxSpareHi = 3'd7;

	typedef enum {DOM_RED, DOM_GREEN, DOM_BLUE} dominant_t;

	typedef struct packed {
		logic [rhc_pkg::CompW-1:0] red;
		logic [rhc_pkg::CompW-1:0] green;
		logic [rhc_pkg::CompW-1:0] blue;
	} rgb_t;

	typedef struct packed {
		rgb_t                px;
		rhc_pkg::hsv_class_t want;
	} hsv_expect_t;

	logic clk = 1'b0;
	logic arst_n;

	rhc_pix_if pix ();
	rhc_hsv_if res ();
	rhc_cfg_if cfg_ch ();

	rgb_to_hsv_color_classifier_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix),
		.result (res),
		.cfg    (cfg_ch)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	rgb_t                         pending_pixels[$];
	hsv_expect_t                  hsv_expected[$];
	logic [rhc_pkg::CfgDataW-1:0] window_reg[NumWindowRegs];
	int unsigned                  src_idle_pct;
	int unsigned                  snk_idle_pct;
	int unsigned                  mismatch_count = 0;
	rgb_t                         next_px;
	hsv_expect_t                  oldest;

	function automatic bit hue_in(input int h, input rhc_pkg::cfg_reg_t lo_idx,
		input rhc_pkg::cfg_reg_t hi_idx);
		return (h > int'(window_reg[lo_idx])) && (h < int'(window_reg[hi_idx]));
	endfunction

	function automatic rhc_pkg::hsv_class_t predict_hsv(input rgb_t px);
		int                  r, g, b, mx, mn, delta, t, h;
		dominant_t           dom;
		rhc_pkg::hsv_class_t o;
		r   = px.red;
		g   = px.green;
		b   = px.blue;
		mx  = r;
		mn  = r;
		dom = DOM_RED;
		if (g > mx) begin
			mx  = g;
			dom = DOM_GREEN;
		end
		if (g < mn) mn = g;
		if (b > mx) begin
			mx  = b;
			dom = DOM_BLUE;
		end
		if (b < mn) mn = b;
		delta = mx - mn;
		h = 0;
		if (delta != 0) begin
			case (dom)
				DOM_RED: begin
					t = 60 * (g - b);
					if (t < 0) t += 360 * delta;
				end
				DOM_GREEN: t = 60 * (2 * delta + b - r);
				default:   t = 60 * (4 * delta + r - g);
			endcase
			h = t / delta;
		end
		o.hue        = rhc_pkg::HueW'(h);
		o.saturation = (mx != 0) ? rhc_pkg::PctW'((100 * delta) / mx) : '0;
		o.lightness  = rhc_pkg::PctW'((100 * mx) / 255);
		// first matching window wins
		if (hue_in(h, rhc_pkg::REG_YELLOW_LO, rhc_pkg::REG_YELLOW_HI))
			o.color_class = rhc_pkg::CLASS_YELLOW;
		else if (hue_in(h, rhc_pkg::REG_BLUE_LO, rhc_pkg::REG_BLUE_HI))
			o.color_class = rhc_pkg::CLASS_BLUE;
		else if (hue_in(h, rhc_pkg::REG_WHITE_LO, rhc_pkg::REG_WHITE_HI))
			o.color_class = rhc_pkg::CLASS_WHITE;
		else
			o.color_class = rhc_pkg::CLASS_NONE;
		return o;
	endfunction

	function automatic rgb_t random_pixel();
		rgb_t                      px;
		int unsigned               kind;
		logic [rhc_pkg::CompW-1:0] hi_v, lo_v;
		kind = $urandom_range(9, 0);
		px   = '{red:   rhc_pkg::CompW'($urandom_range(255, 0)),
			green: rhc_pkg::CompW'($urandom_range(255, 0)),
			blue:  rhc_pkg::CompW'($urandom_range(255, 0))};
		case (kind)
			0: begin
				px.green = px.red;
				px.blue  = px.red;
			end
			1, 2: begin
				// two channels tie for the maximum
				hi_v = rhc_pkg::CompW'($urandom_range(255, 1));
				lo_v = rhc_pkg::CompW'($urandom_range(hi_v - 1, 0));
				case ($urandom_range(2, 0))
					0:       px = '{red: hi_v, green: hi_v, blue: lo_v};
					1:       px = '{red: lo_v, green: hi_v, blue: hi_v};
					default: px = '{red: hi_v, green: lo_v, blue: hi_v};
				endcase
			end
			3: begin
				px.red   = $urandom_range(1, 0) ? 8'hFF - rhc_pkg::CompW'($urandom_range(1, 0))
					: rhc_pkg::CompW'($urandom_range(1, 0));
				px.green = $urandom_range(1, 0) ? 8'hFF - rhc_pkg::CompW'($urandom_range(1, 0))
					: rhc_pkg::CompW'($urandom_range(1, 0));
				px.blue  = $urandom_range(1, 0) ? 8'hFF - rhc_pkg::CompW'($urandom_range(1, 0))
					: rhc_pkg::CompW'($urandom_range(1, 0));
			end
			default: ;
		endcase
		return px;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want,
		input rgb_t px);
		if (mismatch_count < PrintCap)
			$display("[%0t] %s: got %0d, want %0d (rgb %0d,%0d,%0d)", $realtime, what, got,
				want, px.red, px.green, px.blue);
		mismatch_count++;
	endtask

	task automatic add_pixel(input logic [rhc_pkg::CompW-1:0] r,
		input logic [rhc_pkg::CompW-1:0] g, input logic [rhc_pkg::CompW-1:0] b);
		pending_pixels.push_back('{red: r, green: g, blue: b});
	endtask

	task automatic add_random(input int count);
		repeat (count) pending_pixels.push_back(random_pixel());
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_pixels.size() != 0 || pix.valid || hsv_expected.size() != 0);
	endtask

	task automatic write_window_reg(input logic [rhc_pkg::CfgIdxW-1:0] idx,
		input logic [rhc_pkg::CfgDataW-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk);
		while (!cfg_ch.ready);
		if (idx < NumWindowRegs) window_reg[idx] = val;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic load_windows(input int yl, input int yh, input int bl, input int bh,
		input int wl, input int wh);
		write_window_reg(rhc_pkg::REG_YELLOW_LO, rhc_pkg::CfgDataW'(yl));
		write_window_reg(rhc_pkg::REG_YELLOW_HI, rhc_pkg::CfgDataW'(yh));
		write_window_reg(rhc_pkg::REG_BLUE_LO, rhc_pkg::CfgDataW'(bl));
		write_window_reg(rhc_pkg::REG_BLUE_HI, rhc_pkg::CfgDataW'(bh));
		write_window_reg(rhc_pkg::REG_WHITE_LO, rhc_pkg::CfgDataW'(wl));
		write_window_reg(rhc_pkg::REG_WHITE_HI, rhc_pkg::CfgDataW'(wh));
	endtask

	task automatic load_random_windows();
		int yl, bl, wl;
		yl = $urandom_range(359, 0);
		bl = $urandom_range(359, 0);
		wl = $urandom_range(359, 0);
		load_windows(yl, yl + $urandom_range(120, 2), bl, bl + $urandom_range(120, 2),
			wl, wl + $urandom_range(120, 2));
	endtask

	// pixel driver; prediction is made when the transaction completes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
		end else if (!pix.valid || pix.ready) begin
			if (pix.valid)
				hsv_expected.push_back('{px: '{pix.red, pix.green, pix.blue},
					want: predict_hsv('{pix.red, pix.green, pix.blue})});
			if (pending_pixels.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
				next_px = pending_pixels.pop_front();
				pix.valid <= 1'b1;
				pix.red   <= next_px.red;
				pix.green <= next_px.green;
				pix.blue  <= next_px.blue;
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (hsv_expected.size() == 0) begin
				report_mismatch("unexpected result, hue", res.hue, -1, '0);
			end else begin
				oldest = hsv_expected.pop_front();
				if (res.hue !== oldest.want.hue)
					report_mismatch("hue", res.hue, oldest.want.hue, oldest.px);
				if (res.saturation !== oldest.want.saturation)
					report_mismatch("saturation", res.saturation, oldest.want.saturation,
						oldest.px);
				if (res.lightness !== oldest.want.lightness)
					report_mismatch("lightness", res.lightness, oldest.want.lightness,
						oldest.px);
				if (res.color_class !== oldest.want.color_class)
					report_mismatch("color_class", res.color_class, oldest.want.color_class,
						oldest.px);
			end
		end
	end

	initial begin
		pix.valid    = 1'b0;
		pix.red      = '0;
		pix.green    = '0;
		pix.blue     = '0;
		res.ready    = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = rhc_pkg::REG_YELLOW_LO;
		cfg_ch.data  = '0;
		arst_n       = 1'b0;
		window_reg[rhc_pkg::REG_YELLOW_LO] = rhc_pkg::CfgReset.yellow.lo;
		window_reg[rhc_pkg::REG_YELLOW_HI] = rhc_pkg::CfgReset.yellow.hi;
		window_reg[rhc_pkg::REG_BLUE_LO]   = rhc_pkg::CfgReset.blue.lo;
		window_reg[rhc_pkg::REG_BLUE_HI]   = rhc_pkg::CfgReset.blue.hi;
		window_reg[rhc_pkg::REG_WHITE_LO]  = rhc_pkg::CfgReset.white.lo;
		window_reg[rhc_pkg::REG_WHITE_HI]  = rhc_pkg::CfgReset.white.hi;
		src_idle_pct = 8;
		snk_idle_pct = 63;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed, default windows
		add_pixel(8'd0, 8'd0, 8'd0);        // black
		add_pixel(8'd255, 8'd255, 8'd255);  // white, all equal
		add_pixel(8'd128, 8'd128, 8'd128);  // gray
		add_pixel(8'd255, 8'd0, 8'd0);
		add_pixel(8'd0, 8'd255, 8'd0);
		add_pixel(8'd0, 8'd0, 8'd255);
		add_pixel(8'd255, 8'd255, 8'd0);    // red/green tie
		add_pixel(8'd0, 8'd255, 8'd255);    // green/blue tie, hue on blue bound
		add_pixel(8'd255, 8'd0, 8'd255);    // red/blue tie, wraps
		add_pixel(8'd255, 8'd0, 8'd1);      // red sector negative, hue 359
		add_pixel(8'd1, 8'd0, 8'd0);
		add_pixel(8'd0, 8'd1, 8'd0);
		add_pixel(8'd255, 8'd254, 8'd254);
		add_pixel(8'd200, 8'd100, 8'd50);
		add_pixel(8'd50, 8'd200, 8'd100);
		add_pixel(8'd100, 8'd50, 8'd200);
		add_pixel(8'd255, 8'd170, 8'd0);    // hue 40, yellow lower bound
		add_pixel(8'd255, 8'd175, 8'd0);    // hue 41
		add_pixel(8'd0, 8'd250, 8'd255);    // hue 181
		add_pixel(8'd255, 8'd85, 8'd0);     // hue 20, white upper bound
		add_pixel(8'd255, 8'd84, 8'd0);     // hue 19
		add_pixel(8'd255, 8'd1, 8'd0);
		add_random(130);
		wait_drained();

		// widest yellow, inverted blue, degenerate white; spare indexes ignored
		load_windows(0, 360, 360, 0, 511, 511);
		write_window_reg(IdxSpareLo, '1);
		write_window_reg(IdxSpareHi, '0);
		add_random(150);
		wait_drained();

		src_idle_pct = 63;
		snk_idle_pct = 8;
		load_random_windows();
		add_random(150);
		wait_drained();

		load_windows(0, 1, 358, 360, 0, 511);
		add_random(150);
		wait_drained();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		load_random_windows();
		add_random(150);
		wait_drained();

		repeat (rhc_pkg::PipeDepth * 4) @(posedge clk);
		if (mismatch_count == 0 && hsv_expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("timeout, %0d results outstanding", hsv_expected.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
